FILE: hdl/kctf_pkg.sv
// ----------------------------------------------------------------------------
// kctf_pkg
// Shared types, constants and the scan-code translation tables of the
// keyboard change/translate/event queue unit.
// ----------------------------------------------------------------------------
package kctf_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int KEY_CODES   = 256;

   localparam int CODE_W      = 8;
   localparam int KEY_ADDR_W  = $clog2(KEY_CODES);
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W     = 6;
   localparam int EVENT_W     = 10;

   localparam logic [CODE_W-1:0] CHAR_CTRL_LO = 8'h41;   // 'A'
   localparam logic [CODE_W-1:0] CHAR_CTRL_HI = 8'h58;   // 'X'
   localparam logic [CODE_W-1:0] CTRL_OFFSET  = 8'h40;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_INJECT = 2'd1,
      FUNC_POP    = 2'd2
   } func_type;

   typedef struct packed {
      logic              ctrl;
      logic              down;
      logic [CODE_W-1:0] char_code;
   } event_type;

   // Advance a queue pointer with wrap at the queue depth.
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      begin
         if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
         end else begin
            nxt = ptr + 1'b1;
         end
         return nxt;
      end
   endfunction

   // Host scan code to target character; latin selects the Latin table,
   // otherwise the Cyrillic table, which differs on the letter keys and a
   // handful of punctuation keys.
   function automatic logic [CODE_W-1:0] rom_lookup(input logic latin,
                                                    input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] ch;
      begin
         ch = 8'h00;
         if (code >= 8'h20 && code <= 8'h5F) begin
            ch = code;
         end else if (code >= 8'h60 && code <= 8'h6F) begin
            ch = code - 8'h20;
         end else if (code >= 8'h70 && code <= 8'h79) begin
            ch = code + 8'h10;
         end else if (code >= 8'h7A && code <= 8'h7F) begin
            ch = code - 8'h20;
         end else begin
            case (code)
               8'h03:   ch = 8'h03;
               8'h08:   ch = 8'h7F;
               8'h09:   ch = 8'h09;
               8'h0C:   ch = 8'h0C;
               8'h0D:   ch = 8'h0D;
               8'h13:   ch = 8'h13;
               8'hBA:   ch = 8'h3A;
               8'hBB:   ch = 8'h3D;
               8'hBF:   ch = 8'h2F;
               8'hDB:   ch = 8'h5B;
               8'hDD:   ch = 8'h5D;
               default: ch = 8'h00;
            endcase
         end
         if (!latin) begin
            case (code)
               8'h41:   ch = 8'hE6;
               8'h42:   ch = 8'hE9;
               8'h43:   ch = 8'hF3;
               8'h44:   ch = 8'hF7;
               8'h45:   ch = 8'hF5;
               8'h46:   ch = 8'hE1;
               8'h47:   ch = 8'hF0;
               8'h48:   ch = 8'hF2;
               8'h49:   ch = 8'hFB;
               8'h4A:   ch = 8'hEF;
               8'h4B:   ch = 8'hEC;
               8'h4C:   ch = 8'hE4;
               8'h4D:   ch = 8'hF8;
               8'h4E:   ch = 8'hF4;
               8'h4F:   ch = 8'hFD;
               8'h50:   ch = 8'hFA;
               8'h51:   ch = 8'hEA;
               8'h52:   ch = 8'hEB;
               8'h53:   ch = 8'hF9;
               8'h54:   ch = 8'hE5;
               8'h55:   ch = 8'hE7;
               8'h56:   ch = 8'hED;
               8'h57:   ch = 8'hE3;
               8'h58:   ch = 8'hFE;
               8'h59:   ch = 8'hEE;
               8'h5A:   ch = 8'hF1;
               8'hBA:   ch = 8'hF6;
               8'hBC:   ch = 8'hE2;
               8'hBE:   ch = 8'hE0;
               8'hC0:   ch = 8'hE5;
               8'hDB:   ch = 8'hE8;
               8'hDD:   ch = 8'h00;
               8'hDE:   ch = 8'hFC;
               default: ch = ch;
            endcase
         end
         return ch;
      end
   endfunction

endpackage

FILE: hdl/kctf_ram.sv
// ----------------------------------------------------------------------------
// kctf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kctf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/keyboard_change_translate_fifo_unit.sv
// ----------------------------------------------------------------------------
// keyboard_change_translate_fifo_unit
// Key change detection, scan-code translation and a queue of key events.
// ----------------------------------------------------------------------------
// Flow: an accepted request is held in the s1 registers while its RAM reads
//    complete; its response is registered once the response register is free or being taken.
// Ordering: one request at a time; the key-state and event RAMs are read in the
//    accept cycle and written back when the request retires.
// Reset (synchronous, active high): all keys released, queue empty, Latin
//    layout selected, no response pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyboard_change_translate_fifo_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [kctf_pkg::CODE_W-1:0]   req_key_code,
   input  logic                          req_key_down,
   input  logic                          req_ctrl_held,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_event_queued,
   output logic                          rsp_event_dropped,
   output logic                          rsp_popped_valid,
   output logic [kctf_pkg::CODE_W-1:0]   rsp_popped_char,
   output logic                          rsp_popped_down,
   output logic                          rsp_popped_ctrl,
   output logic [kctf_pkg::LEVEL_W-1:0]  rsp_queue_level,
   // layout register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_latin_layout
);

   import kctf_pkg::*;

   // Layout register
   logic latin_layout_ff;

   // Request held while its RAM reads complete
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_func_ff;
   logic [CODE_W-1:0]     s1_code_ff;
   logic                  s1_down_ff;
   logic                  s1_ctrl_ff;

   // Queue pointers and fill count
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // One valid bit per key; a key never written reads as released
   logic [KEY_CODES-1:0]  key_valid_ff;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  queued_ff, queued_in;
   logic                  dropped_ff, dropped_in;
   logic                  pvalid_ff, pvalid_in;
   logic [CODE_W-1:0]     pchar_ff, pchar_in;
   logic                  pdown_ff, pdown_in;
   logic                  pctrl_ff, pctrl_in;

   // RAM interfaces
   logic                  key_q;
   logic [EVENT_W-1:0]    event_q;
   event_type             event_rd;
   event_type             event_wr;
   logic                  push_en;
   logic                  key_wr_en;

   logic                  req_accept;
   logic                  s1_fire;
   logic                  prev_down;
   logic [CODE_W-1:0]     ch;
   logic                  queue_full;

   // One request at a time: hold the request side while one is in flight.
   assign req_stall  = s1_valid_ff;
   assign req_accept = req_valid && !req_stall;

   // Retire the request once the response register is free or being taken.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready  = 1'b1;

   // Per-key previous down state
   kctf_ram #(
      .WIDTH (1),
      .DEPTH (KEY_CODES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (s1_code_ff[KEY_ADDR_W-1:0]),
      .wr_data (s1_down_ff),
      .rd_en   (req_accept),
      .rd_addr (req_key_code[KEY_ADDR_W-1:0]),
      .rd_data (key_q)
   );

   // Event queue storage; the head entry is read at accept time
   kctf_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (event_wr),
      .rd_en   (req_accept),
      .rd_addr (rd_ptr_ff),
      .rd_data (event_q)
   );

   assign event_rd   = event_type'(event_q);
   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign prev_down  = key_valid_ff[s1_code_ff[KEY_ADDR_W-1:0]] & key_q;
   assign key_wr_en  = s1_fire && (s1_func_ff == FUNC_SAMPLE);

   always_comb begin
      ch           = rom_lookup(latin_layout_ff, s1_code_ff);
      if (s1_ctrl_ff && ch >= CHAR_CTRL_LO && ch <= CHAR_CTRL_HI) begin
         ch = ch - CTRL_OFFSET;
      end

      push_en      = 1'b0;
      event_wr     = '0;
      queued_in    = 1'b0;
      dropped_in   = 1'b0;
      pvalid_in    = 1'b0;
      pchar_in     = '0;
      pdown_in     = 1'b0;
      pctrl_in     = 1'b0;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;

      case (s1_func_ff)
         FUNC_SAMPLE: begin
            // Event only on a change of state with a non-zero character
            if (prev_down != s1_down_ff && ch != '0) begin
               event_wr.char_code = ch;
               event_wr.down      = s1_down_ff;
               event_wr.ctrl      = s1_ctrl_ff;
               queued_in          = !queue_full;
               dropped_in         = queue_full;
            end
         end
         FUNC_INJECT: begin
            // Raw event, control always clear, zero character allowed
            event_wr.char_code = s1_code_ff;
            event_wr.down      = s1_down_ff;
            event_wr.ctrl      = 1'b0;
            queued_in          = !queue_full;
            dropped_in         = queue_full;
         end
         FUNC_POP: begin
            if (count_ff != '0) begin
               pvalid_in = 1'b1;
               pchar_in  = event_rd.char_code;
               pdown_in  = event_rd.down;
               pctrl_in  = event_rd.ctrl;
               if (s1_fire) begin
                  rd_ptr_in = next_ptr(rd_ptr_ff);
                  count_in  = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (queued_in && s1_fire) begin
         push_en   = 1'b1;
         wr_ptr_in = next_ptr(wr_ptr_ff);
         count_in  = count_ff + 1'b1;
      end
   end

   // Load the response on retire; drop it once taken.
   always_comb begin
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latin_layout_ff <= 1'b1;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
         key_valid_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            latin_layout_ff <= csr_latin_layout;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         if (key_wr_en) begin
            key_valid_ff[s1_code_ff[KEY_ADDR_W-1:0]] <= 1'b1;
         end
      end
   end

   // Payload registers: capture request, capture response on retire
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff <= req_func;
         s1_code_ff <= req_key_code;
         s1_down_ff <= req_key_down;
         s1_ctrl_ff <= req_ctrl_held;
      end
      if (s1_fire) begin
         queued_ff  <= queued_in;
         dropped_ff <= dropped_in;
         pvalid_ff  <= pvalid_in;
         pchar_ff   <= pchar_in;
         pdown_ff   <= pdown_in;
         pctrl_ff   <= pctrl_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_queued  = queued_ff;
   assign rsp_event_dropped = dropped_ff;
   assign rsp_popped_valid  = pvalid_ff;
   assign rsp_popped_char   = pchar_ff;
   assign rsp_popped_down   = pdown_ff;
   assign rsp_popped_ctrl   = pctrl_ff;
   // Level follows the count once the response is loaded: the count moves
   // only at the edge that loads a new response, so it cannot change while
   // the response waits.
   assign rsp_queue_level   = LEVEL_W'(count_ff);

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("event count above queue depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("queue empty but pointers differ");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_accept)
      else $error("request accepted while another is in flight");

   a_pop_no_push: assert property (@(posedge clock) disable iff (reset)
      s1_fire && pvalid_in |-> !push_en && !dropped_in)
      else $error("pop and push in the same request");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_fire && dropped_in |-> queue_full && $stable(count_ff))
      else $error("event dropped with room in the queue");

endmodule

FILE: verif/keyboard_change_translate_fifo_unit_tb.sv
// ----------------------------------------------------------------------------
// keyboard_change_translate_fifo_unit_tb
// Self-checking bench for the key change detector, scan-code translator and
// event queue. A short table of directed requests is followed by random
// phases under both layouts. Every request is predicted here and each
// response is compared in order. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module keyboard_change_translate_fifo_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kctf_pkg::*;

   // Function code with no operation behind it: the block only reports the level.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Control folding turns 'A'..'X' into codes 0x01..0x18.
   localparam logic [CODE_W-1:0] CTRL_FIRST = "A";
   localparam logic [CODE_W-1:0] CTRL_LAST  = "X";
   localparam logic [CODE_W-1:0] CTRL_SHIFT = 8'h40;

   // Cyrillic characters for the letter keys 0x41..0x5A, first key first.
   localparam logic [26*8-1:0] CYRILLIC_LETTERS = {
      8'hE6, 8'hE9, 8'hF3, 8'hF7, 8'hF5, 8'hE1, 8'hF0, 8'hF2, 8'hFB,
      8'hEF, 8'hEC, 8'hE4, 8'hF8, 8'hF4, 8'hFD, 8'hFA, 8'hEA, 8'hEB,
      8'hF9, 8'hE5, 8'hE7, 8'hED, 8'hE3, 8'hFE, 8'hEE, 8'hF1};

   // Keys whose translation is special in one layout or the other.
   localparam int          SPECIAL_COUNT = 15;
   localparam logic [SPECIAL_COUNT*8-1:0] SPECIAL_KEYS = {
      8'h03, 8'h08, 8'h09, 8'h0C, 8'h0D, 8'h13, 8'hBA, 8'hBB,
      8'hBC, 8'hBE, 8'hBF, 8'hC0, 8'hDB, 8'hDD, 8'hDE};

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic               queued;
      logic               dropped;
      logic               pop_valid;
      logic [CODE_W-1:0]  pop_char;
      logic               pop_down;
      logic               pop_ctrl;
      logic [LEVEL_W-1:0] level;
   } key_outcome_type;

   typedef struct {
      logic [1:0]        func;
      logic [CODE_W-1:0] code;
      logic              down;
      logic              ctrl;
      logic              pinned;
      key_outcome_type   want;
   } key_request_type;

   // DUT ports; every input starts at a known value.
   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func         = FUNC_SAMPLE;
   logic [CODE_W-1:0]  req_key_code     = '0;
   logic               req_key_down     = 1'b0;
   logic               req_ctrl_held    = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic               rsp_event_queued;
   logic               rsp_event_dropped;
   logic               rsp_popped_valid;
   logic [CODE_W-1:0]  rsp_popped_char;
   logic               rsp_popped_down;
   logic               rsp_popped_ctrl;
   logic [LEVEL_W-1:0] rsp_queue_level;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic               csr_latin_layout = 1'b1;

   // Predictor state: layout, per-key held bits and the event queue.
   logic               latin_now;
   logic               key_held [KEY_CODES];
   event_type          event_queue [$];
   logic [CODE_W-1:0]  latin_chars [KEY_CODES];
   logic [CODE_W-1:0]  cyrillic_chars [KEY_CODES];

   key_outcome_type    expected_outcomes [$];
   key_request_type    directed_rows [$];

   logic calm = 1'b0;   // high: neither side idles
   int   cycle_count    = 0;
   int   error_count    = 0;
   int   requests_sent  = 0;
   int   events_queued  = 0;
   int   events_dropped = 0;
   int   pops_with_data = 0;
   int   layout_writes  = 0;
   int   deepest_level  = 0;

   keyboard_change_translate_fifo_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_key_code      (req_key_code),
      .req_key_down      (req_key_down),
      .req_ctrl_held     (req_ctrl_held),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_queued  (rsp_event_queued),
      .rsp_event_dropped (rsp_event_dropped),
      .rsp_popped_valid  (rsp_popped_valid),
      .rsp_popped_char   (rsp_popped_char),
      .rsp_popped_down   (rsp_popped_down),
      .rsp_popped_ctrl   (rsp_popped_ctrl),
      .rsp_queue_level   (rsp_queue_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_latin_layout  (csr_latin_layout)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_outcomes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Response side back-pressure: stall at random with a chance of 38 in a hundred,
   // never while the bench is in a calm stretch.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 38);
      end
   end

   // Check each accepted response against the oldest expectation.
   always @(posedge clock) begin
      key_outcome_type seen;
      key_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_event_queued, rsp_event_dropped, rsp_popped_valid,
                  rsp_popped_char, rsp_popped_down, rsp_popped_ctrl,
                  rsp_queue_level};
         if (expected_outcomes.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < REPORT_LIMIT) begin
               $display("cycle %0d: response with no request outstanding", cycle_count);
            end
         end else begin
            want = expected_outcomes.pop_front();
            if (seen !== want) begin
               error_count <= error_count + 1;
               if (error_count < REPORT_LIMIT) begin
                  $display("cycle %0d: expected q%0b d%0b v%0b ch %h dn%0b ct%0b lvl %0d",
                           cycle_count, want.queued, want.dropped, want.pop_valid,
                           want.pop_char, want.pop_down, want.pop_ctrl, want.level);
                  $display("            got      q%0b d%0b v%0b ch %h dn%0b ct%0b lvl %0d",
                           seen.queued, seen.dropped, seen.pop_valid,
                           seen.pop_char, seen.pop_down, seen.pop_ctrl, seen.level);
               end
            end
         end
      end
   end

   // Fill both translation tables; Cyrillic starts as a copy of Latin.
   task automatic build_tables();
      for (int i = 0; i < KEY_CODES; i++) begin
         latin_chars[i] = '0;
         key_held[i]    = 1'b0;
      end
      latin_chars[8'h03] = 8'h03;
      latin_chars[8'h08] = 8'h7F;   // backspace maps to delete
      latin_chars[8'h09] = 8'h09;
      latin_chars[8'h0C] = 8'h0C;
      latin_chars[8'h0D] = 8'h0D;
      latin_chars[8'h13] = 8'h13;
      for (int i = 8'h20; i <= 8'h5F; i++) latin_chars[i] = CODE_W'(i);
      for (int i = 8'h60; i <= 8'h6F; i++) latin_chars[i] = CODE_W'(i - 8'h20);
      for (int i = 8'h70; i <= 8'h79; i++) latin_chars[i] = CODE_W'(i + 8'h10);
      for (int i = 8'h7A; i <= 8'h7F; i++) latin_chars[i] = CODE_W'(i - 8'h20);
      latin_chars[8'hBA] = 8'h3A;
      latin_chars[8'hBB] = 8'h3D;
      latin_chars[8'hBF] = 8'h2F;
      latin_chars[8'hDB] = 8'h5B;
      latin_chars[8'hDD] = 8'h5D;
      cyrillic_chars = latin_chars;
      for (int k = 0; k < 26; k++) begin
         cyrillic_chars[8'h41 + k] = CYRILLIC_LETTERS[(25 - k)*8 +: 8];
      end
      cyrillic_chars[8'hBA] = 8'hF6;
      cyrillic_chars[8'hBC] = 8'hE2;
      cyrillic_chars[8'hBE] = 8'hE0;
      cyrillic_chars[8'hC0] = 8'hE5;
      cyrillic_chars[8'hDB] = 8'hE8;
      cyrillic_chars[8'hDD] = 8'h00;
      cyrillic_chars[8'hDE] = 8'hFC;
   endtask

   // Enqueue one event, or drop it when the queue is full.
   task automatic queue_event(input event_type ev, inout key_outcome_type o);
      if (event_queue.size() < QUEUE_DEPTH) begin
         event_queue.push_back(ev);
         o.queued = 1'b1;
         events_queued++;
      end else begin
         o.dropped = 1'b1;
         events_dropped++;
      end
   endtask

   // Advance the key/queue state by one request and return its response.
   task automatic predict_outcome(input logic [1:0] func, input logic [CODE_W-1:0] code,
                                  input logic down, input logic ctrl,
                                  output key_outcome_type o);
      logic [CODE_W-1:0] ch;
      event_type         ev;
      o = '0;
      case (func)
         FUNC_SAMPLE: begin
            if (key_held[code] != down) begin
               ch = latin_now ? latin_chars[code] : cyrillic_chars[code];
               if (ctrl && ch >= CTRL_FIRST && ch <= CTRL_LAST) begin
                  ch = ch - CTRL_SHIFT;
               end
               if (ch != '0) begin
                  ev = '{ctrl: ctrl, down: down, char_code: ch};
                  queue_event(ev, o);
               end
            end
            key_held[code] = down;
         end
         FUNC_INJECT: begin
            // raw injection: control never recorded, even a zero code goes in
            ev = '{ctrl: 1'b0, down: down, char_code: code};
            queue_event(ev, o);
         end
         FUNC_POP: begin
            if (event_queue.size() != 0) begin
               ev          = event_queue.pop_front();
               o.pop_valid = 1'b1;
               o.pop_char  = ev.char_code;
               o.pop_down  = ev.down;
               o.pop_ctrl  = ev.ctrl;
               pops_with_data++;
            end
         end
         default: begin
         end
      endcase
      o.level = LEVEL_W'(event_queue.size());
      if (event_queue.size() > deepest_level) deepest_level = event_queue.size();
   endtask

   // Present one request, hold it until accepted, then record its response.
   task automatic send_request(input logic [1:0] func, input logic [CODE_W-1:0] code,
                               input logic down, input logic ctrl,
                               input logic pinned, input key_outcome_type want);
      key_outcome_type got;
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_key_code  <= code;
      req_key_down  <= down;
      req_ctrl_held <= ctrl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_outcome(func, code, down, ctrl, got);
      // typed-in rows take the hand-written response, the state still advances
      expected_outcomes.push_back(pinned ? want : got);
      requests_sent++;
   endtask

   // Drop valid, wait for every outstanding response, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the layout register; only called with the block idle.
   task automatic write_layout(input logic latin);
      csr_valid        <= 1'b1;
      csr_latin_layout <= latin;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      latin_now = latin;
      csr_valid <= 1'b0;
      layout_writes++;
   endtask

   function automatic key_outcome_type outcome(input int q, input int d, input int v,
                                               input logic [CODE_W-1:0] ch, input int dn,
                                               input int ct, input int lvl);
      key_outcome_type o;
      o = '{1'(q), 1'(d), 1'(v), ch, 1'(dn), 1'(ct), LEVEL_W'(lvl)};
      return o;
   endfunction

   task automatic add_row(input logic [1:0] func, input logic [CODE_W-1:0] code,
                          input logic down, input logic ctrl,
                          input logic pinned, input key_outcome_type want);
      key_request_type row;
      row = '{func, code, down, ctrl, pinned, want};
      directed_rows.push_back(row);
   endtask

   // Bias sample codes towards keys that translate to something.
   function automatic logic [CODE_W-1:0] pick_key_code();
      logic [CODE_W-1:0] code;
      int                k;
      k = $urandom_range(SPECIAL_COUNT - 1);
      case ($urandom_range(3))
         0:       code = CODE_W'($urandom_range(255));
         1:       code = CODE_W'($urandom_range(8'h5A, 8'h41));
         2:       code = SPECIAL_KEYS[k*8 +: 8];
         default: code = CODE_W'($urandom_range(8'h7F, 8'h60));
      endcase
      return code;
   endfunction

   // Random requests: the mix of inject/sample/pop sets how full the queue runs.
   task automatic run_random_phase(input int count, input int inject_pct,
                                   input int sample_pct, input int calm_items);
      logic [1:0]        func;
      logic [CODE_W-1:0] code;
      logic              down;
      logic              ctrl;
      int                r;
      for (int n = 0; n < count; n++) begin
         calm <= (n < calm_items);
         r = $urandom_range(99);
         if (r < 3) begin
            func = FUNC_UNUSED;
         end else if (r < 3 + inject_pct) begin
            func = FUNC_INJECT;
         end else if (r < 3 + inject_pct + sample_pct) begin
            func = FUNC_SAMPLE;
         end else begin
            func = FUNC_POP;
         end
         code = (func == FUNC_SAMPLE) ? pick_key_code() : CODE_W'($urandom_range(255));
         ctrl = 1'($urandom_range(1));
         // mostly toggle the key so that samples produce events
         if (func == FUNC_SAMPLE && $urandom_range(9) < 7) begin
            down = !key_held[code];
         end else begin
            down = 1'($urandom_range(1));
         end
         send_request(func, code, down, ctrl, 1'b0, '0);
      end
      calm <= 1'b0;
   endtask

   initial begin
      build_tables();
      latin_now = 1'b1;   // layout after reset is Latin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, Latin layout from reset.
      add_row(FUNC_POP,    8'h00, 1'b0, 1'b0, 1'b1, outcome(0, 0, 0, 8'h00, 0, 0, 0));
      add_row(FUNC_SAMPLE, 8'h41, 1'b1, 1'b0, 1'b1, outcome(1, 0, 0, 8'h00, 0, 0, 1));
      // key already down: refresh only
      add_row(FUNC_SAMPLE, 8'h41, 1'b1, 1'b0, 1'b1, outcome(0, 0, 0, 8'h00, 0, 0, 1));
      add_row(FUNC_SAMPLE, 8'h41, 1'b0, 1'b1, 1'b0, '0);
      // code translating to zero makes no event
      add_row(FUNC_SAMPLE, 8'h00, 1'b1, 1'b0, 1'b1, outcome(0, 0, 0, 8'h00, 0, 0, 2));
      add_row(FUNC_SAMPLE, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
      // injected zero code still queued, control ignored
      add_row(FUNC_INJECT, 8'h00, 1'b1, 1'b1, 1'b1, outcome(1, 0, 0, 8'h00, 0, 0, 3));
      add_row(FUNC_INJECT, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(FUNC_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, outcome(0, 0, 0, 8'h00, 0, 0, 4));
      // control folding edges: just past 'X', 'X' itself, just below 'A'
      add_row(FUNC_SAMPLE, 8'h59, 1'b1, 1'b1, 1'b0, '0);
      add_row(FUNC_SAMPLE, 8'h58, 1'b1, 1'b1, 1'b0, '0);
      add_row(FUNC_SAMPLE, 8'h40, 1'b1, 1'b1, 1'b0, '0);
      add_row(FUNC_SAMPLE, 8'h61, 1'b1, 1'b1, 1'b0, '0);
      add_row(FUNC_SAMPLE, 8'h08, 1'b1, 1'b0, 1'b0, '0);
      add_row(FUNC_POP,    8'h00, 1'b0, 1'b0, 1'b1, outcome(0, 0, 1, 8'h41, 1, 0, 8));
      // pop ignores code, down and control
      add_row(FUNC_POP,    8'hFF, 1'b1, 1'b1, 1'b0, '0);
      for (int i = 0; i < 7; i++) add_row(FUNC_POP, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(FUNC_POP,    8'h00, 1'b0, 1'b0, 1'b1, outcome(0, 0, 0, 8'h00, 0, 0, 0));

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].func, directed_rows[i].code, directed_rows[i].down,
                      directed_rows[i].ctrl, directed_rows[i].pinned, directed_rows[i].want);
      end
      // Hold the sender until the queue of responses is empty before each write.
      settle();

      write_layout(1'b0);
      run_random_phase(300, 15, 45, 0);
      settle();
      // Push-heavy: fill the queue and force drops.
      write_layout(1'b1);
      run_random_phase(300, 30, 50, 0);
      settle();
      // Pop-heavy, opening with a long calm stretch.
      write_layout(1'b0);
      run_random_phase(300, 10, 30, 150);
      settle();
      write_layout(1'b1);
      run_random_phase(325, 15, 45, 0);
      settle();
      repeat (8) @(posedge clock);

      $display("Ran %0d requests over %0d layout writes in %0d cycles; deepest queue %0d.",
               requests_sent, layout_writes, cycle_count, deepest_level);
      $display("Events queued %0d, dropped %0d, popped %0d; mismatches %0d.",
               events_queued, events_dropped, pops_with_data, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/kctf_pkg.sv
hdl/kctf_ram.sv
hdl/keyboard_change_translate_fifo_unit.sv
verif/keyboard_change_translate_fifo_unit_tb.sv
